>>> hdl/cle_pkg.sv
// Shared types, constants and helpers for the console line editor.
package cle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = 5;
    localparam int CFG_W      = 6;
    localparam int CAP_LIMIT  = (LINE_DEPTH - 1 > 31) ? 31 : LINE_DEPTH - 1;
    localparam int ERASE_LEN  = 7;

    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(CAP_LIMIT);
    localparam logic [CFG_W-1:0] BS_RESET  = CFG_W'(32);
    localparam logic [CFG_W-1:0] BS_DEPTH  = CFG_W'(LINE_DEPTH);

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_CANCEL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ERASE,
        ST_CR_CHAR,
        ST_CR_DONE
    } t_state;

    typedef enum logic [2:0] {
        SRC_ECHO_RX,
        SRC_ERASE,
        SRC_CHAR,
        SRC_DONE,
        SRC_CANCEL
    } t_src;

    typedef struct packed {
        logic take_in;
        logic out_load;
        t_src src;
        logic cnt_clr;
        logic cnt_inc;
        logic cnt_dec;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic is_esc;
        logic is_cr;
        logic is_del;
        logic is_print;
        logic cnt_zero;
        logic has_room;
        logic out_free;
        logic char_last;
        logic erase_last;
    } t_status;

    // Cursor-back, blank, cursor-back sequence sent for a delete.
    function automatic logic [7:0] erase_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0, 3'd4: b = CH_ESC;
            3'd1, 3'd5: b = CH_LBRACKET;
            3'd2, 3'd6: b = CH_D;
            3'd3:       b = CH_SPACE;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/cle_ctrl.sv
// Controller state machine of the console line editor.
module cle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cle_pkg::t_status i_status,
    output cle_pkg::t_cmd    o_cmd
);

    cle_pkg::t_state r_state;
    cle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.src  = cle_pkg::SRC_ECHO_RX;
        unique case (r_state)
            cle_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = cle_pkg::ST_DISPATCH;
                end
            end
            cle_pkg::ST_DISPATCH: begin
                // wait for a free output slot, then act on the byte
                if (i_status.out_free) begin
                    n_state = cle_pkg::ST_IDLE;
                    if (i_status.is_esc) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.src      = cle_pkg::SRC_CANCEL;
                        o_cmd.cnt_clr  = 1'b1;
                    end else if (i_status.is_cr) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = i_status.cnt_zero ? cle_pkg::ST_CR_DONE
                                                    : cle_pkg::ST_CR_CHAR;
                    end else if (i_status.is_del) begin
                        if (!i_status.cnt_zero) begin
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                            n_state       = cle_pkg::ST_ERASE;
                        end
                    end else if (i_status.is_print && i_status.has_room) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.src      = cle_pkg::SRC_ECHO_RX;
                        o_cmd.cnt_inc  = 1'b1;
                    end
                end
            end
            cle_pkg::ST_ERASE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.src      = cle_pkg::SRC_ERASE;
                    if (i_status.erase_last) begin
                        n_state = cle_pkg::ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            cle_pkg::ST_CR_CHAR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.src      = cle_pkg::SRC_CHAR;
                    if (i_status.char_last) begin
                        n_state = cle_pkg::ST_CR_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            cle_pkg::ST_CR_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.src      = cle_pkg::SRC_DONE;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = cle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cle_dpath.sv
// Datapath of the console line editor: line store, counters and output register.
module cle_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cle_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [7:0]                  i_rx_byte,
    input  cle_pkg::t_cmd               i_cmd,
    output cle_pkg::t_status            o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_out_kind,
    output logic [7:0]                  o_out_byte,
    output logic [cle_pkg::CNT_W-1:0]   o_out_len,
    output logic                        o_out_last
);

    logic [cle_pkg::CFG_W-1:0] r_bsize;
    logic [7:0]                r_rx;
    logic [cle_pkg::CNT_W-1:0] r_count;
    logic [cle_pkg::CNT_W-1:0] n_count;
    logic [cle_pkg::CNT_W-1:0] r_idx;
    logic [cle_pkg::CNT_W-1:0] n_idx;
    logic [cle_pkg::CNT_W-1:0] w_cap;
    logic [cle_pkg::CNT_W-1:0] w_idx_next;
    logic [7:0]                r_rd_data;
    logic [7:0]                r_mem [cle_pkg::LINE_DEPTH];

    logic                      r_out_valid;
    cle_pkg::t_kind            r_out_kind;
    logic [7:0]                r_out_byte;
    logic [cle_pkg::CNT_W-1:0] r_out_len;
    logic                      r_out_last;
    logic                      w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize <= cle_pkg::BS_RESET;
        end else if (i_cfg_we) begin
            r_bsize <= i_cfg_wdata;
        end
    end

    // usable characters: buffer size less one, clipped to the store
    always_comb begin
        if (r_bsize == '0) begin
            w_cap = '0;
        end else if (r_bsize > cle_pkg::BS_DEPTH) begin
            w_cap = cle_pkg::CAP_MAX;
        end else begin
            w_cap = cle_pkg::CNT_W'(r_bsize - cle_pkg::CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_rx <= i_rx_byte;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + cle_pkg::CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - cle_pkg::CNT_W'(1);
        end
    end

    assign w_idx_next = r_idx + cle_pkg::CNT_W'(1);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = w_idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // read data always tracks the entry at the running index
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_inc) begin
            r_mem[r_count[cle_pkg::IDX_W-1:0]] <= r_rx;
        end
        r_rd_data <= r_mem[n_idx[cle_pkg::IDX_W-1:0]];
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_len  <= '0;
            r_out_byte <= '0;
            r_out_last <= 1'b1;
            case (i_cmd.src)
                cle_pkg::SRC_ECHO_RX: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= r_rx;
                end
                cle_pkg::SRC_ERASE: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= cle_pkg::erase_byte(r_idx[2:0]);
                    r_out_last <= o_status.erase_last;
                end
                cle_pkg::SRC_CHAR: begin
                    r_out_kind <= cle_pkg::KIND_CHAR;
                    r_out_byte <= r_rd_data;
                    r_out_last <= 1'b0;
                end
                cle_pkg::SRC_DONE: begin
                    r_out_kind <= cle_pkg::KIND_DONE;
                    r_out_len  <= r_count;
                end
                default: begin
                    r_out_kind <= cle_pkg::KIND_CANCEL;
                end
            endcase
        end
    end

    always_comb begin
        o_status.is_esc     = (r_rx == cle_pkg::CH_ESC);
        o_status.is_cr      = (r_rx == cle_pkg::CH_CR);
        o_status.is_del     = (r_rx == cle_pkg::CH_DEL);
        o_status.is_print   = (r_rx >= cle_pkg::CH_PRINT_LO) &&
                              (r_rx <= cle_pkg::CH_PRINT_HI);
        o_status.cnt_zero   = (r_count == '0);
        o_status.has_room   = (r_count < w_cap);
        o_status.out_free   = w_out_free;
        o_status.char_last  = (w_idx_next == r_count);
        o_status.erase_last = (r_idx == cle_pkg::CNT_W'(cle_pkg::ERASE_LEN - 1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("result loaded over one not yet taken");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cle_pkg::CAP_MAX)
        else $error("character count beyond store");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (i_cmd.src == cle_pkg::SRC_DONE ||
                            i_cmd.src == cle_pkg::SRC_CANCEL)) |=> (r_count == '0))
        else $error("line not cleared after done or cancel");

    a_char_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && i_cmd.src == cle_pkg::SRC_CHAR) |-> (r_idx < r_count))
        else $error("line character read beyond count");

endmodule

>>> hdl/console_line_editor.sv
// Top level of the console line editor: controller plus datapath.
//
// Usage:
//   s_axis carries one received console byte per beat in tdata[7:0].
//   m_axis carries result beats: tuser is the kind (echo, line character,
//   line done, line cancelled), tdata holds the byte and the line length,
//   and tlast marks the final result caused by one received byte.
//   i_cfg_we / i_cfg_wdata write the buffer size; write it only while idle.
// Timing:
//   A byte is taken only in the idle state and is then acted on in the dispatch
//   step of the controller. A printable byte with room in the line, or ESC, loads
//   its result into the output register from dispatch; an ignored byte or a delete
//   on an empty line loads none. For DEL and CR the erase or carriage-return steps
//   that follow dispatch load the seven erase bytes, or the line characters and
//   the done beat, one result leaving per cycle while the output side takes every
//   beat.
// Reset:
//   The line is emptied and the buffer size returns to 32; store contents
//   are left as they were and are never read before being written.
// Back-pressure:
//   While m_axis_tready is low the result waits in the output register and
//   the controller holds; a new byte may be taken while a final result waits.
module console_line_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: buffer size
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [12:8] line_length, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    cle_pkg::t_cmd              w_cmd;
    cle_pkg::t_status           w_status;
    logic [7:0]                 w_out_byte;
    logic [cle_pkg::CNT_W-1:0]  w_out_len;

    // sequence each byte's work
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // hold the line and drive the result register
    cle_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_byte  (w_out_byte),
        .o_out_len   (w_out_len),
        .o_out_last  (m_axis_tlast)
    );

    // pack byte and length, pad to whole bytes
    assign m_axis_tdata = {3'b000, w_out_len, w_out_byte};

endmodule
